@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdW   = 8;
  localparam int unsigned PrioW = 32;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_LIST = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_LIST  = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
  } entry_t;

endpackage

@@ design/spq_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cmp
// Shared priority comparator: decides whether a stored entry yields its
// place to the new entry (strict at the head, non-strict further down).
// ----------------------------------------------------------------------------
module spq_cmp (
  input  logic signed [spq_pkg::PrioW-1:0] slot_prio_i,
  input  logic signed [spq_pkg::PrioW-1:0] new_prio_i,
  input  logic                             strict_i,
  output logic                             move_o
);

  logic lt;
  logic eq;

  assign lt     = slot_prio_i < new_prio_i;
  assign eq     = slot_prio_i == new_prio_i;
  assign move_o = lt | (eq & ~strict_i);

endmodule

@@ design/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Descending-priority list in a slot memory with one write and one read port,
// walked by a small sequencer that shares one comparator for insertion.
// ----------------------------------------------------------------------------
// Add to an empty or full queue, and remove or list on an empty queue, answer
//   from idle in the cycle after start. Add otherwise: moves each entry down
//   one slot from the tail until the new one fits, then writes it. Remove:
//   result at the head visit, busy until every entry is pulled up. List: one result per slot.
// Each slot visit reads the slot memory, then evaluates the read entry.
// Reset clears the entry count and the sequencer; slots need no clearing.
// Results are strobed for one cycle; the receiver cannot stall.
module sorted_priority_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action_i,
  input  logic [spq_pkg::IdW-1:0]          process_id_i,
  input  logic signed [spq_pkg::PrioW-1:0] priority_req_i,
  output logic                             result_valid_o,
  output logic [2:0]                       status_o,
  output logic [spq_pkg::IdW-1:0]          entry_id_o,
  output logic signed [spq_pkg::PrioW-1:0] entry_priority_o,
  output logic                             last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EVAL = 4'b0100,
    S_PUT  = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  spq_pkg::action_e            op_q, op_d;
  spq_pkg::entry_t             new_q, new_d;
  logic [spq_pkg::AddrW-1:0]   idx_q, idx_d;
  logic [spq_pkg::CntW-1:0]    cnt_q, cnt_d;
  spq_pkg::entry_t             rd_q;

  logic                        vld_q, vld_d;
  spq_pkg::status_e            st_q, st_d;
  spq_pkg::entry_t             oe_q, oe_d;
  logic                        last_q, last_d;

  logic                        we;
  logic [spq_pkg::AddrW-1:0]   waddr;
  spq_pkg::entry_t             wdata;

  spq_pkg::entry_t             mem [spq_pkg::Depth];

  logic                        full;
  logic                        empty;
  logic                        idx_last;
  logic                        move;
  spq_pkg::entry_t             in_entry;

  assign full     = cnt_q == spq_pkg::CntW'(spq_pkg::Depth);
  assign empty    = cnt_q == '0;
  assign idx_last = spq_pkg::CntW'(idx_q) == (cnt_q - spq_pkg::CntW'(1));
  assign in_entry = '{id: process_id_i, prio: priority_req_i};

  spq_cmp u_cmp (
    .slot_prio_i (rd_q.prio),
    .new_prio_i  (new_q.prio),
    .strict_i    (idx_q == '0),
    .move_o      (move)
  );

  // slot memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[idx_q];
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    new_d   = new_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    vld_d   = 1'b0;
    st_d    = st_q;
    oe_d    = oe_q;
    last_d  = last_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = new_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d  = spq_pkg::action_e'(action_i);
          new_d = in_entry;
          unique case (spq_pkg::action_e'(action_i))
            spq_pkg::ACT_ADD: begin
              if (full) begin
                vld_d  = 1'b1;
                st_d   = spq_pkg::ST_FULL;
                oe_d   = in_entry;
                last_d = 1'b1;
              end else if (empty) begin
                we     = 1'b1;
                waddr  = '0;
                wdata  = in_entry;
                cnt_d  = spq_pkg::CntW'(1);
                vld_d  = 1'b1;
                st_d   = spq_pkg::ST_ENQ;
                oe_d   = in_entry;
                last_d = 1'b1;
              end else begin
                // scan from the tail toward the head
                idx_d   = spq_pkg::AddrW'(cnt_q - spq_pkg::CntW'(1));
                state_d = S_RD;
              end
            end
            spq_pkg::ACT_RUN, spq_pkg::ACT_LIST: begin
              if (empty) begin
                vld_d  = 1'b1;
                st_d   = spq_pkg::ST_EMPTY;
                oe_d   = '0;
                last_d = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            spq_pkg::ACT_NONE: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        state_d = S_EVAL;
      end

      S_EVAL: begin
        unique case (op_q)
          spq_pkg::ACT_ADD: begin
            if (move) begin
              we    = 1'b1;
              waddr = idx_q + spq_pkg::AddrW'(1);
              wdata = rd_q;
              if (idx_q == '0) begin
                state_d = S_PUT;
              end else begin
                idx_d   = idx_q - spq_pkg::AddrW'(1);
                state_d = S_RD;
              end
            end else begin
              idx_d   = idx_q + spq_pkg::AddrW'(1);
              state_d = S_PUT;
            end
          end
          spq_pkg::ACT_RUN: begin
            if (idx_q == '0) begin
              vld_d  = 1'b1;
              st_d   = spq_pkg::ST_DEQ;
              oe_d   = rd_q;
              last_d = 1'b1;
            end else begin
              // pull the entry up one slot
              we    = 1'b1;
              waddr = idx_q - spq_pkg::AddrW'(1);
              wdata = rd_q;
            end
            if (idx_last) begin
              cnt_d   = cnt_q - spq_pkg::CntW'(1);
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + spq_pkg::AddrW'(1);
              state_d = S_RD;
            end
          end
          spq_pkg::ACT_LIST: begin
            vld_d  = 1'b1;
            st_d   = spq_pkg::ST_LIST;
            oe_d   = rd_q;
            last_d = idx_last;
            if (idx_last) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + spq_pkg::AddrW'(1);
              state_d = S_RD;
            end
          end
          spq_pkg::ACT_NONE: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = new_q;
        cnt_d   = cnt_q + spq_pkg::CntW'(1);
        vld_d   = 1'b1;
        st_d    = spq_pkg::ST_ENQ;
        oe_d    = new_q;
        last_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      op_q    <= spq_pkg::ACT_NONE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    st_q   <= st_d;
    oe_q   <= oe_d;
    last_q <= last_d;
  end

  assign busy             = state_q != S_IDLE;
  assign result_valid_o   = vld_q;
  assign status_o         = st_q;
  assign entry_id_o       = oe_q.id;
  assign entry_priority_o = oe_q.prio;
  assign last_o           = last_q;

  // count never runs past the slot array
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spq_pkg::CntW'(spq_pkg::Depth))
    else $error("entry count out of range");

  // an add to a full queue is answered at once with a drop
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == spq_pkg::ACT_ADD && full)
      |=> (result_valid_o && status_o == spq_pkg::ST_FULL && last_o && !busy))
    else $error("full add not dropped");

  // an enqueue always leaves at least one entry
  a_enq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == spq_pkg::ST_ENQ) |-> !empty)
    else $error("enqueue with empty count");

  // evaluate only follows a memory read cycle
  a_eval_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ($past(state_q) == S_RD))
    else $error("evaluate without read");

  // a dequeue result only comes from a non-empty queue
  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == spq_pkg::ST_DEQ) |-> ($past(cnt_q) != '0))
    else $error("dequeue from empty queue");

endmodule
